@@ rtl/sse_pkg.sv @@
package sse_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int DATA_W        = 32;

   // What one cell shows its neighbors.
   typedef struct packed {
      logic                     occ;
      logic                     gt;
      logic signed [DATA_W-1:0] val;
   } cell_link_type;

   // Row-wide command from the controller.
   typedef struct packed {
      logic insert;
      logic shift;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      ST_LOAD = 2'b01,
      ST_EMIT = 2'b10
   } ctrl_state_type;

endpackage

@@ rtl/sse_cell.sv @@
module sse_cell
   import sse_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cell_cmd_type             cmd,
   input  logic signed [DATA_W-1:0] new_val,
   input  cell_link_type            left,
   input  cell_link_type            right,
   output cell_link_type            self_link
);

   logic signed [DATA_W-1:0] val_ff, val_in;
   logic                     occ_ff, occ_in;
   logic                     gt;

   assign gt = occ_ff && (val_ff > new_val);

   always_comb begin
      val_in = val_ff;
      occ_in = occ_ff;
      if (cmd.insert) begin
         // Larger neighbor on the left moves in; otherwise take the new value here
         // if this is the first slot past the smaller-or-equal run.
         if (left.gt) begin
            val_in = left.val;
            occ_in = 1'b1;
         end else if (left.occ && (!occ_ff || gt)) begin
            val_in = new_val;
            occ_in = 1'b1;
         end
      end else if (cmd.shift) begin
         val_in = right.val;
         occ_in = right.occ;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   assign self_link = '{occ: occ_ff, gt: gt, val: val_ff};

endmodule

@@ rtl/sse_ctrl.sv @@
module sse_ctrl
   import sse_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_last,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic         rsp_sorted_last,
   output logic         rsp_overflow,
   output cell_cmd_type cmd
);

   localparam int CW = $clog2(DEPTH + 1);

   ctrl_state_type state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           ovf_ff, ovf_in;
   logic           in_beat, out_beat, full;

   assign full      = (count_ff == CW'(DEPTH));
   assign req_stall = (state_ff != ST_LOAD);
   assign rsp_valid = (state_ff == ST_EMIT);
   assign in_beat   = req_valid && !req_stall;
   assign out_beat  = rsp_valid && !rsp_stall;

   assign rsp_sorted_last = (count_ff == CW'(1));
   assign rsp_overflow    = ovf_ff;

   assign cmd.insert = in_beat && !full;
   assign cmd.shift  = out_beat;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      case (state_ff)
         ST_LOAD: begin
            if (in_beat) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  count_in = count_ff + CW'(1);
               end
               if (req_last) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (out_beat) begin
               count_in = count_ff - CW'(1);
               if (rsp_sorted_last) begin
                  state_in = ST_LOAD;
                  ovf_in   = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
            count_in = '0;
            ovf_in   = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.insert && cmd.shift))
      else $error("insert and shift in the same cycle");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("fill count above capacity");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (count_ff != '0))
      else $error("emitting from an empty row");

   a_batch_done: assert property (@(posedge clock) disable iff (reset)
      (out_beat && rsp_sorted_last) |=> (count_ff == '0 && !ovf_ff && !rsp_valid))
      else $error("batch state not cleared after last beat");

   a_overflow_only_full: assert property (@(posedge clock) disable iff (reset)
      (!$past(ovf_ff) && ovf_ff) |-> (count_ff == CW'(DEPTH)))
      else $error("overflow set with room in the row");

endmodule

@@ rtl/shell_sort_engine.sv @@
// Channel  | Dir | Ports                                        | Beat
// request  | in  | req_valid req_stall req_value req_last       | one value, last marks batch end
// response | out | rsp_valid rsp_stall rsp_sorted_value         | one value in ascending order
//          |     | rsp_sorted_last rsp_overflow                 |
//
// Each accepted request beat is inserted into a row of DEPTH sorted cells with one
// compare per cell, so the row is always in order. After the last beat the row
// shifts out one response beat per cycle while rsp_stall is low; no request is
// taken until the last response beat is accepted. Reset clears the occupancy of
// every cell, the fill count and the overflow flag. Stalls on either side simply
// hold the row; beats past DEPTH are dropped.
module shell_sort_engine
   import sse_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     req_last,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_sorted_value,
   output logic                     rsp_sorted_last,
   output logic                     rsp_overflow
);

   cell_cmd_type  cmd;
   cell_link_type links [DEPTH];

   sse_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_last        (req_last),
      .req_stall       (req_stall),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sorted_last (rsp_sorted_last),
      .rsp_overflow    (rsp_overflow),
      .cmd             (cmd)
   );

   localparam cell_link_type HEAD_LINK = '{occ: 1'b1, gt: 1'b0, val: '0};
   localparam cell_link_type TAIL_LINK = '{occ: 1'b0, gt: 1'b0, val: '0};

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_link_type left_link, right_link;

      if (i == 0) begin : g_head
         assign left_link = HEAD_LINK;
      end else begin : g_left
         assign left_link = links[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_link = TAIL_LINK;
      end else begin : g_right
         assign right_link = links[i+1];
      end

      sse_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .new_val   (req_value),
         .left      (left_link),
         .right     (right_link),
         .self_link (links[i])
      );
   end

   assign rsp_sorted_value = links[0].val;

endmodule

@@ verif/tb_shell_sort_engine.sv @@
`timescale 1ns / 100ps

module tb_shell_sort_engine;
   import sse_pkg::*;

   localparam int DEPTH        = DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 2 * DEPTH + 16;
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_AFTER   = 30;

   typedef struct {
      logic signed [DATA_W-1:0] value;
      logic                     last;
   } batch_beat_type;

   typedef struct {
      logic signed [DATA_W-1:0] value;
      logic                     last;
      logic                     overflow;
   } sorted_beat_type;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_ALTERNATE,
      STALL_HEAVY
   } stall_mode_type;

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     req_last  = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_sorted_value;
   logic                     rsp_sorted_last;
   logic                     rsp_overflow;

   shell_sort_engine #(.DEPTH(DEPTH)) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_sorted_last  (rsp_sorted_last),
      .rsp_overflow     (rsp_overflow)
   );

   batch_beat_type  pending_beats[$];
   sorted_beat_type sorted_expect_q[$];

   // Running batch, kept in ascending order as values arrive.
   logic signed [DATA_W-1:0] held_sorted[DEPTH];
   int                       held_count    = 0;
   logic                     held_overflow = 1'b0;

   int batches_done     = 0;
   int overflow_batches = 0;
   int beats_in         = 0;
   int beats_out        = 0;
   int mismatches       = 0;
   int cycle_count      = 0;

   int             burst_left = 0;
   int             gap_left   = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left  = 0;
   int             hold_left  = 0;
   logic           hold_done  = 1'b0;
   int             hold_watch = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic absorb_beat(input logic signed [DATA_W-1:0] v, input logic is_last);
      int              pos;
      sorted_beat_type sb;
      if (held_count < DEPTH) begin
         pos = held_count;
         while (pos > 0 && held_sorted[pos-1] > v) begin
            held_sorted[pos] = held_sorted[pos-1];
            pos--;
         end
         held_sorted[pos] = v;
         held_count++;
      end else begin
         held_overflow = 1'b1;
      end
      if (is_last) begin
         for (int k = 0; k < held_count; k++) begin
            sb.value    = held_sorted[k];
            sb.last     = (k == held_count - 1);
            sb.overflow = held_overflow;
            sorted_expect_q.push_back(sb);
         end
         batches_done++;
         if (held_overflow)
            overflow_batches++;
         held_count    = 0;
         held_overflow = 1'b0;
      end
   endtask

   task automatic flag_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s", $time, msg);
   endtask

   task automatic queue_value(input logic signed [DATA_W-1:0] v, input logic is_last);
      batch_beat_type b;
      b.value = v;
      b.last  = is_last;
      pending_beats.push_back(b);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom;
         4, 5:       return $signed($urandom_range(0, 16)) - 8;
         6:          return 32'h8000_0000 + $urandom_range(0, 3);
         7:          return 32'h7FFF_FFFF - $urandom_range(0, 3);
         default:    return $urandom & 32'h8000_00FF;
      endcase
   endfunction

   task automatic queue_batch(input int size);
      for (int k = 0; k < size; k++)
         queue_value(pick_value(), k == size - 1);
   endtask

   // Driver: bursts of beats with random gaps, payload held while stalled.
   always @(posedge clock) begin : driver
      batch_beat_type nb;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            absorb_beat(req_value, req_last);
            beats_in++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0 || pending_beats.size() == 0) begin
               req_valid <= 1'b0;
               if (gap_left > 0)
                  gap_left--;
            end else begin
               nb = pending_beats.pop_front();
               req_valid <= 1'b1;
               req_value <= nb.value;
               req_last  <= nb.last;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 20);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   // Long hold-off on the response side once results start flowing.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall)
            hold_watch++;
         if (hold_left != 0)
            hold_left <= hold_left - 1;
         else if (!hold_done && hold_watch >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
         end
      end
   end

   // Monitor: check each accepted result beat, then pick the next stall.
   always @(posedge clock) begin : monitor
      sorted_beat_type want;
      logic            stall_bit;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            beats_out++;
            if (sorted_expect_q.size() == 0) begin
               flag_mismatch($sformatf("unexpected beat: value %0d last %0b overflow %0b",
                                       rsp_sorted_value, rsp_sorted_last, rsp_overflow));
            end else begin
               want = sorted_expect_q.pop_front();
               if (rsp_sorted_value !== want.value || rsp_sorted_last !== want.last ||
                   rsp_overflow !== want.overflow)
                  flag_mismatch($sformatf(
                     "beat %0d: expected value %0d last %0b overflow %0b, got %0d %0b %0b",
                     beats_out, want.value, want.last, want.overflow,
                     rsp_sorted_value, rsp_sorted_last, rsp_overflow));
            end
         end
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 80);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            STALL_NONE:      stall_bit = 1'b0;
            STALL_LIGHT:     stall_bit = ($urandom_range(0, 2) == 0);
            STALL_ALTERNATE: stall_bit = cycle_count[0];
            default:         stall_bit = ($urandom_range(0, 2) != 0);
         endcase
         rsp_stall <= (hold_left != 0) || stall_bit;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats still expected",
                  cycle_count, sorted_expect_q.size());
         $display("tb_shell_sort_engine NOT OK");
         $finish;
      end
   end

   initial begin
      int small_beats;

      // Single beat batch at the top of the range.
      queue_value(32'h7FFF_FFFF, 1'b1);
      // Range extremes and values around zero.
      queue_value(32'h8000_0000, 1'b0);
      queue_value(32'h7FFF_FFFF, 1'b0);
      queue_value(0, 1'b0);
      queue_value(-1, 1'b0);
      queue_value(1, 1'b0);
      queue_value(32'h8000_0001, 1'b0);
      queue_value(32'h7FFF_FFFE, 1'b1);
      // Repeated values.
      queue_value(5, 1'b0);
      queue_value(5, 1'b0);
      queue_value(-5, 1'b0);
      queue_value(5, 1'b1);
      // Descending, then already sorted.
      for (int k = 0; k < 6; k++)
         queue_value(40 - 10 * k, k == 5);
      for (int k = 0; k < 4; k++)
         queue_value(-100 + k, k == 3);

      // Overflow batch whose last beat is dropped.
      queue_batch(DEPTH + $urandom_range(1, 4));
      small_beats = 0;
      while (small_beats < 40) begin
         int size;
         size = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
         queue_batch(size);
         small_beats += size;
      end

      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock); while (pending_beats.size() != 0 || req_valid);
      while (sorted_expect_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d batches (%0d with overflow): %0d beats in, %0d sorted beats out.",
               batches_done, overflow_batches, beats_in, beats_out);
      $display("Response side held off once for %0d cycles; %0d mismatches.",
               HOLD_CYCLES, mismatches);
      if (mismatches == 0)
         $display("tb_shell_sort_engine OK");
      else
         $display("tb_shell_sort_engine NOT OK");
      $finish;
   end

endmodule
